// ===== hdl/bitmap_page_allocator_top_defines.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bpa_pkg.sv =====
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int NUM_WORDS  = 1024;
    localparam int WORD_BITS  = 64;
    localparam int PAGE_BYTES = 4096;

    localparam int ADDR_W     = $clog2(NUM_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int CNT_W      = $clog2(NUM_WORDS + 1);
    localparam int PIDX_W     = ADDR_W + BIT_W;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    localparam int REQ_W      = 2;
    localparam int PAGE_W     = 16;
    localparam int ADDR_OUT_W = 28;
    localparam int SCAN_W     = 11;

    localparam logic [SCAN_W-1:0] SCAN_RESET = SCAN_W'(1024);
    localparam longint TOTAL_PAGES = longint'(NUM_WORDS) * longint'(WORD_BITS);

    localparam logic [REQ_W-1:0] REQ_FREE  = REQ_W'(0);
    localparam logic [REQ_W-1:0] REQ_LOCK  = REQ_W'(1);
    localparam logic [REQ_W-1:0] REQ_ALLOC = REQ_W'(2);

    typedef logic [1:0] t_res_sel;
    localparam t_res_sel RES_FAIL  = 2'd0;
    localparam t_res_sel RES_DONE  = 2'd1;
    localparam t_res_sel RES_GRANT = 2'd2;

    typedef struct packed {
        logic     cnt_clr;
        logic     clear_wr;
        logic     cap_req;
        logic     rmw_rd;
        logic     rmw_wr;
        logic     scan_rd;
        logic     grant_wr;
        logic     load_out;
        t_res_sel res_sel;
    } t_bpa_cmd;

    typedef struct packed {
        logic             clear_last;
        logic             page_ok;
        logic             lim_zero;
        logic             rd_vld;
        logic             rd_full;
        logic             rd_last;
        logic [REQ_W-1:0] req_type;
    } t_bpa_stat;

endpackage

// ===== hdl/bpa_req_if.sv =====
`timescale 1ns / 1ps

interface bpa_req_if;
    logic                         valid;
    logic                         ready;
    logic [bpa_pkg::REQ_W-1:0]    req_type;
    logic [bpa_pkg::PAGE_W-1:0]   page_index;

    modport source (output valid, output req_type, output page_index, input ready);
    modport sink   (input valid, input req_type, input page_index, output ready);
endinterface

// ===== hdl/bpa_rsp_if.sv =====
`timescale 1ns / 1ps

interface bpa_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             success;
    logic [bpa_pkg::PAGE_W-1:0]       alloc_page;
    logic [bpa_pkg::ADDR_OUT_W-1:0]   alloc_address;

    modport source (output valid, output success, output alloc_page, output alloc_address,
                    input ready);
    modport sink   (input valid, input success, input alloc_page, input alloc_address,
                    output ready);
endinterface

// ===== hdl/bpa_ram.sv =====
`timescale 1ns / 1ps

module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bpa_ctrl.sv =====
`timescale 1ns / 1ps

module bpa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bpa_pkg::t_bpa_cmd   o_cmd,
    input  bpa_pkg::t_bpa_stat  i_stat
);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_RMW_WR   = 3'd3;
    localparam logic [2:0] S_SCAN     = 3'd4;
    localparam logic [2:0] S_GRANT    = 3'd5;
    localparam logic [2:0] S_RESP     = 3'd6;

    logic [2:0]        r_state, n_state;
    bpa_pkg::t_res_sel r_res, n_res;
    logic              r_out_valid, n_out_valid;
    logic              accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.res_sel = r_res;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.cap_req = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.req_type)
                    bpa_pkg::REQ_FREE, bpa_pkg::REQ_LOCK: begin
                        if (i_stat.page_ok) begin
                            o_cmd.rmw_rd = 1'b1;
                            n_state      = S_RMW_WR;
                        end else begin
                            n_res   = bpa_pkg::RES_FAIL;
                            n_state = S_RESP;
                        end
                    end
                    bpa_pkg::REQ_ALLOC: begin
                        if (i_stat.lim_zero) begin
                            n_res   = bpa_pkg::RES_FAIL;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_res   = bpa_pkg::RES_FAIL;
                        n_state = S_RESP;
                    end
                endcase
            end
            S_RMW_WR: begin
                o_cmd.rmw_wr = 1'b1;
                n_res        = bpa_pkg::RES_DONE;
                n_state      = S_RESP;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.rd_vld && !i_stat.rd_full) begin
                    n_state = S_GRANT;
                end else if (i_stat.rd_vld && i_stat.rd_last) begin
                    n_res   = bpa_pkg::RES_FAIL;
                    n_state = S_RESP;
                end
            end
            S_GRANT: begin
                o_cmd.grant_wr = 1'b1;
                n_res          = bpa_pkg::RES_GRANT;
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_res       <= bpa_pkg::RES_FAIL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res       <= n_res;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hdl/bpa_datapath.sv =====
`timescale 1ns / 1ps

module bpa_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bpa_pkg::t_bpa_cmd                  i_cmd,
    output bpa_pkg::t_bpa_stat                 o_stat,
    input  logic [bpa_pkg::REQ_W-1:0]          i_req_type,
    input  logic [bpa_pkg::PAGE_W-1:0]         i_page_index,
    input  logic [bpa_pkg::SCAN_W-1:0]         i_scan_words,
    output logic                               o_success,
    output logic [bpa_pkg::PAGE_W-1:0]         o_alloc_page,
    output logic [bpa_pkg::ADDR_OUT_W-1:0]     o_alloc_address
);

    localparam logic [bpa_pkg::WORD_BITS-1:0] FULL_WORD = '1;

    function automatic logic [bpa_pkg::BIT_W-1:0] bit_pos(
        input logic [bpa_pkg::WORD_BITS-1:0] onehot
    );
        logic [bpa_pkg::BIT_W-1:0] pos;
        pos = '0;
        for (int j = 0; j < bpa_pkg::WORD_BITS; j++) begin
            if (onehot[j]) begin
                pos = pos | bpa_pkg::BIT_W'(j);
            end
        end
        return pos;
    endfunction

    logic [bpa_pkg::CNT_W-1:0]      r_cnt;
    logic [bpa_pkg::REQ_W-1:0]      r_req;
    logic [bpa_pkg::PAGE_W-1:0]     r_page;
    logic                           r_rd_vld;
    logic [bpa_pkg::ADDR_W-1:0]     r_rd_addr;
    logic [bpa_pkg::WORD_BITS-1:0]  r_word;
    logic [bpa_pkg::ADDR_W-1:0]     r_waddr;
    logic                           r_success;
    logic [bpa_pkg::PAGE_W-1:0]     r_alloc_page;
    logic [bpa_pkg::ADDR_OUT_W-1:0] r_alloc_address;

    logic [bpa_pkg::CNT_W-1:0]      lim;
    logic                           issue;
    logic [bpa_pkg::ADDR_W-1:0]     page_word;
    logic [bpa_pkg::WORD_BITS-1:0]  page_mask;
    logic [bpa_pkg::WORD_BITS-1:0]  rd_data;
    logic [bpa_pkg::WORD_BITS-1:0]  free_bits;
    logic [bpa_pkg::WORD_BITS-1:0]  low_free;
    logic [bpa_pkg::PIDX_W-1:0]     grant_page;
    logic                           ram_we;
    logic [bpa_pkg::ADDR_W-1:0]     ram_waddr;
    logic [bpa_pkg::WORD_BITS-1:0]  ram_wdata;
    logic                           ram_re;
    logic [bpa_pkg::ADDR_W-1:0]     ram_raddr;

    assign lim = (32'(i_scan_words) > 32'(bpa_pkg::NUM_WORDS))
                 ? bpa_pkg::CNT_W'(bpa_pkg::NUM_WORDS) : bpa_pkg::CNT_W'(i_scan_words);
    assign issue     = i_cmd.scan_rd && (r_cnt < lim);
    assign page_word = bpa_pkg::ADDR_W'(r_page >> bpa_pkg::BIT_W);
    assign page_mask = bpa_pkg::WORD_BITS'(1) << r_page[bpa_pkg::BIT_W-1:0];

    assign free_bits  = ~r_word;
    assign low_free   = free_bits & (~free_bits + bpa_pkg::WORD_BITS'(1));
    assign grant_page = {r_waddr, bit_pos(low_free)};

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt[bpa_pkg::ADDR_W-1:0];
        ram_wdata = FULL_WORD;
        if (i_cmd.clear_wr) begin
            ram_we = 1'b1;
        end else if (i_cmd.rmw_wr) begin
            ram_we    = 1'b1;
            ram_waddr = page_word;
            ram_wdata = (r_req == bpa_pkg::REQ_FREE) ? (rd_data & ~page_mask)
                                                     : (rd_data | page_mask);
        end else if (i_cmd.grant_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_waddr;
            ram_wdata = r_word | low_free;
        end
    end

    assign ram_re    = i_cmd.rmw_rd || issue;
    assign ram_raddr = i_cmd.rmw_rd ? page_word : r_cnt[bpa_pkg::ADDR_W-1:0];

    bpa_ram #(
        .WIDTH (bpa_pkg::WORD_BITS),
        .DEPTH (bpa_pkg::NUM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.clear_wr || issue) begin
                r_cnt <= r_cnt + bpa_pkg::CNT_W'(1);
            end
            r_rd_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_req) begin
            r_req  <= i_req_type;
            r_page <= i_page_index;
        end
        if (issue) begin
            r_rd_addr <= r_cnt[bpa_pkg::ADDR_W-1:0];
        end
        if (i_cmd.scan_rd && r_rd_vld) begin
            r_word  <= rd_data;
            r_waddr <= r_rd_addr;
        end
        if (i_cmd.load_out) begin
            case (i_cmd.res_sel)
                bpa_pkg::RES_DONE: begin
                    r_success       <= 1'b1;
                    r_alloc_page    <= '0;
                    r_alloc_address <= '0;
                end
                bpa_pkg::RES_GRANT: begin
                    r_success       <= 1'b1;
                    r_alloc_page    <= bpa_pkg::PAGE_W'(grant_page);
                    r_alloc_address <= bpa_pkg::ADDR_OUT_W'(
                        {grant_page, {bpa_pkg::PAGE_SHIFT{1'b0}}});
                end
                default: begin
                    r_success       <= 1'b0;
                    r_alloc_page    <= '0;
                    r_alloc_address <= '0;
                end
            endcase
        end
    end

    assign o_stat.clear_last = (r_cnt == bpa_pkg::CNT_W'(bpa_pkg::NUM_WORDS - 1));
    assign o_stat.page_ok    = (64'(r_page) < 64'(bpa_pkg::TOTAL_PAGES));
    assign o_stat.lim_zero   = (lim == '0);
    assign o_stat.rd_vld     = r_rd_vld;
    assign o_stat.rd_full    = (rd_data == FULL_WORD);
    assign o_stat.rd_last    = ((bpa_pkg::CNT_W'(r_rd_addr) + bpa_pkg::CNT_W'(1)) == lim);
    assign o_stat.req_type   = r_req;

    assign o_success       = r_success;
    assign o_alloc_page    = r_alloc_page;
    assign o_alloc_address = r_alloc_address;

endmodule

// ===== hdl/bitmap_page_allocator_top.sv =====
// Bitmap page allocator, first fit, one bit per page (1 = used).
// i_req (valid/ready): req_type free, lock or alloc, plus page_index.
// o_rsp (valid/ready): success, alloc_page, alloc_address; one beat per request.
// i_cfg_we/i_cfg_wdata write scan_words, the number of 64-page words alloc
// searches; write it only while the block is idle.
// One request is in flight at a time. Free and lock of a page in range do
// a read and a write of the bitmap RAM before the response.
// Alloc reads one bitmap word per cycle, as the single RAM read port allows,
// until it hits a word with a free page or has read scan_words words.
// Reset (synchronous, active low) fills all 1024 words with ones, one word
// per cycle; i_req.ready stays low until the fill is done.
// Results sit in an output register; a stalled receiver holds that beat,
// and the next request still runs, waiting only to load its own result.

`timescale 1ns / 1ps
`include "bitmap_page_allocator_top_defines.svh"

module bitmap_page_allocator_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bpa_req_if.sink                     i_req,
    bpa_rsp_if.source                   o_rsp,
    input  logic                        i_cfg_we,
    input  logic [bpa_pkg::SCAN_W-1:0]  i_cfg_wdata
);

    logic [bpa_pkg::SCAN_W-1:0] r_scan_words;
    bpa_pkg::t_bpa_cmd          cmd;
    bpa_pkg::t_bpa_stat         stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_words <= bpa_pkg::SCAN_RESET;
        end else if (i_cfg_we) begin
            r_scan_words <= i_cfg_wdata;
        end
    end

    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    bpa_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_req_type      (i_req.req_type),
        .i_page_index    (i_req.page_index),
        .i_scan_words    (r_scan_words),
        .o_success       (o_rsp.success),
        .o_alloc_page    (o_rsp.alloc_page),
        .o_alloc_address (o_rsp.alloc_address)
    );

    `BPA_ASSERT_NOW(a_no_accept_in_clear, cmd.clear_wr, !i_req.ready,
                    "request taken during clear")
    `BPA_ASSERT_NOW(a_one_ram_write, 1'b1,
                    $onehot0({cmd.clear_wr, cmd.rmw_wr, cmd.grant_wr}),
                    "two RAM writes at once")
    `BPA_ASSERT_NOW(a_grant_after_hit, cmd.grant_wr,
                    $past(stat.rd_vld && !stat.rd_full), "grant without a scan hit")
    `BPA_ASSERT_NEXT(a_load_shows_beat, cmd.load_out, o_rsp.valid,
                     "loaded result not presented")

endmodule

// ===== test/tb_bitmap_page_allocator_top.sv =====
`timescale 1ns / 1ps

module tb_bitmap_page_allocator_top;
    import bpa_pkg::*;

    localparam logic [REQ_W-1:0] REQ_BAD = REQ_W'(3);
    localparam int HOLD_CYCLES = 90;
    localparam int TAIL_CYCLES = 30;

    typedef enum logic [2:0] {PL_BEAT, PL_CFG, PL_DRAIN, PL_HOLD, PL_CALM} plan_cmd_t;

    typedef struct packed {
        plan_cmd_t           cmd;
        logic [REQ_W-1:0]    req_type;
        logic [PAGE_W-1:0]   page_index;
        logic [SCAN_W-1:0]   scan_val;
    } plan_t;

    typedef struct packed {
        logic                    success;
        logic [PAGE_W-1:0]       alloc_page;
        logic [ADDR_OUT_W-1:0]   alloc_address;
    } grant_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [SCAN_W-1:0] i_cfg_wdata;

    bpa_req_if req_if ();
    bpa_rsp_if rsp_if ();

    bitmap_page_allocator_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // shadow of the allocator state
    logic [WORD_BITS-1:0] page_map [NUM_WORDS];
    logic [SCAN_W-1:0]    scan_cfg;

    plan_t  req_plan [$];
    grant_t grant_expect [$];

    logic req_taken;
    logic hold_go;
    logic calm;
    int   tx_gap;
    int   rx_gap;
    int   hold_left;
    int   err_cnt;
    int   n_grant, n_nofree, n_rw, n_bad, n_cfg;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic grant_t page_map_apply(logic [REQ_W-1:0] rt, logic [PAGE_W-1:0] pg);
        grant_t r;
        int     lim;
        int     pidx;
        r = '0;
        if (rt == REQ_ALLOC) begin
            lim = (scan_cfg > NUM_WORDS) ? NUM_WORDS : int'(scan_cfg);
            for (int w = 0; w < lim && !r.success; w++) begin
                if (page_map[w] != '1) begin
                    for (int b = 0; b < WORD_BITS && !r.success; b++) begin
                        if (!page_map[w][b]) begin
                            page_map[w][b] = 1'b1;
                            pidx = w * WORD_BITS + b;
                            r.success = 1'b1;
                            r.alloc_page = PAGE_W'(pidx);
                            r.alloc_address = ADDR_OUT_W'(longint'(pidx) * PAGE_BYTES);
                        end
                    end
                end
            end
            if (r.success) n_grant++;
            else n_nofree++;
        end else if ((rt == REQ_FREE || rt == REQ_LOCK) && longint'(pg) < TOTAL_PAGES) begin
            page_map[pg / WORD_BITS][pg % WORD_BITS] = (rt == REQ_LOCK);
            r.success = 1'b1;
            n_rw++;
        end else begin
            n_bad++;
        end
        return r;
    endfunction

    // accept side: prediction, config tracking, response checking
    always @(posedge i_clk) begin : mon
        grant_t exp_g;
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                scan_cfg = i_cfg_wdata;
                n_cfg++;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (grant_expect.size() == 0) begin
                    $error("response beat with no request outstanding");
                    err_cnt++;
                end else begin
                    exp_g = grant_expect.pop_front();
                    if (rsp_if.success !== exp_g.success) begin
                        $error("success mismatch: expected %0d, actual %0d",
                               exp_g.success, rsp_if.success);
                        err_cnt++;
                    end
                    if (rsp_if.alloc_page !== exp_g.alloc_page) begin
                        $error("alloc_page mismatch: expected %0d, actual %0d",
                               exp_g.alloc_page, rsp_if.alloc_page);
                        err_cnt++;
                    end
                    if (rsp_if.alloc_address !== exp_g.alloc_address) begin
                        $error("alloc_address mismatch: expected %0h, actual %0h",
                               exp_g.alloc_address, rsp_if.alloc_address);
                        err_cnt++;
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                grant_expect.push_back(page_map_apply(req_if.req_type, req_if.page_index));
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin : drv
        plan_t head;
        logic  v;
        logic  we_v;
        logic  go_v;
        we_v = 1'b0;
        go_v = 1'b0;
        if (i_rst_n && !(req_if.valid && !req_taken)) begin
            v = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (req_plan.size() != 0) begin
                head = req_plan[0];
                case (head.cmd)
                    PL_BEAT: begin
                        if (!calm && $urandom_range(0, 3) == 0) begin
                            tx_gap = $urandom_range(1, 11) - 1;
                        end else begin
                            v = 1'b1;
                            req_if.req_type <= head.req_type;
                            req_if.page_index <= head.page_index;
                            void'(req_plan.pop_front());
                        end
                    end
                    PL_DRAIN: begin
                        if (grant_expect.size() == 0) void'(req_plan.pop_front());
                    end
                    PL_CFG: begin
                        if (grant_expect.size() == 0) begin
                            we_v = 1'b1;
                            i_cfg_wdata <= head.scan_val;
                            void'(req_plan.pop_front());
                        end
                    end
                    PL_HOLD: begin
                        go_v = 1'b1;
                        void'(req_plan.pop_front());
                    end
                    default: begin
                        calm <= 1'b1;
                        void'(req_plan.pop_front());
                    end
                endcase
            end
            req_if.valid <= v;
        end
        i_cfg_we <= we_v;
        hold_go <= go_v;
    end

    // response receiver
    always @(negedge i_clk) begin : rcv
        logic r;
        r = 1'b1;
        if (hold_go) hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            r = 1'b0;
            hold_left--;
        end else if (rx_gap > 0) begin
            r = 1'b0;
            rx_gap--;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            r = 1'b0;
            rx_gap = $urandom_range(1, 11) - 1;
        end
        rsp_if.ready <= r;
    end

    task automatic add_beat(logic [REQ_W-1:0] rt, logic [PAGE_W-1:0] pg);
        req_plan.push_back('{cmd: PL_BEAT, req_type: rt, page_index: pg, scan_val: '0});
    endtask

    task automatic add_cmd(plan_cmd_t c, logic [SCAN_W-1:0] val);
        req_plan.push_back('{cmd: c, req_type: REQ_FREE, page_index: '0, scan_val: val});
    endtask

    task automatic add_random_beats(int n, int scan);
        int eff;
        int hi;
        int sel;
        logic [PAGE_W-1:0] pg;
        eff = (scan > NUM_WORDS) ? NUM_WORDS : scan;
        hi = (eff + 1) * WORD_BITS - 1;
        if (hi > 65535) hi = 65535;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 85) pg = PAGE_W'($urandom_range(0, hi));
            else pg = PAGE_W'($urandom);
            if (sel < 38) add_beat(REQ_ALLOC, PAGE_W'($urandom));
            else if (sel < 70) add_beat(REQ_FREE, pg);
            else if (sel < 90) add_beat(REQ_LOCK, pg);
            else if (sel < 95) add_beat(REQ_BAD, pg);
            else add_beat(REQ_FREE, PAGE_W'($urandom));
        end
    endtask

    initial begin
        int phase_scan [8];
        int phase_len  [8];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_FREE;
        req_if.page_index = '0;
        rsp_if.ready = 1'b0;
        req_taken = 1'b0;
        hold_go = 1'b0;
        calm = 1'b0;
        tx_gap = 0;
        rx_gap = 0;
        hold_left = 0;
        err_cnt = 0;
        n_grant = 0;
        n_nofree = 0;
        n_rw = 0;
        n_bad = 0;
        n_cfg = 0;
        scan_cfg = SCAN_RESET;
        for (int w = 0; w < NUM_WORDS; w++) page_map[w] = '1;

        // directed: full map after reset, edge pages, scan limits
        add_cmd(PL_CFG, SCAN_W'(1024));
        add_beat(REQ_ALLOC, '0);
        add_beat(REQ_FREE, PAGE_W'(0));
        add_beat(REQ_FREE, PAGE_W'(65535));
        add_beat(REQ_FREE, PAGE_W'(63));
        add_beat(REQ_FREE, PAGE_W'(64));
        add_beat(REQ_ALLOC, '1);
        add_beat(REQ_ALLOC, '0);
        add_beat(REQ_ALLOC, '0);
        add_beat(REQ_ALLOC, '0);
        add_beat(REQ_LOCK, PAGE_W'(0));
        add_beat(REQ_FREE, PAGE_W'(0));
        add_beat(REQ_LOCK, PAGE_W'(0));
        add_beat(REQ_BAD, PAGE_W'(0));
        add_beat(REQ_BAD, PAGE_W'(65535));
        add_beat(REQ_FREE, PAGE_W'(16'h5555));
        add_beat(REQ_FREE, PAGE_W'(16'hAAAA));
        add_cmd(PL_CFG, SCAN_W'(0));
        add_beat(REQ_FREE, PAGE_W'(5));
        add_beat(REQ_ALLOC, '0);
        add_cmd(PL_CFG, SCAN_W'(1));
        add_beat(REQ_ALLOC, '0);
        add_beat(REQ_FREE, PAGE_W'(70));
        add_beat(REQ_ALLOC, '0);
        add_cmd(PL_CFG, SCAN_W'(2047));
        add_beat(REQ_ALLOC, '0);
        add_beat(REQ_ALLOC, '0);

        phase_scan = '{16, 3, 1024, 64, 2047, 1, 0, 8};
        phase_len  = '{60, 50, 50, 50, 40, 40, 25, 50};
        for (int p = 0; p < 8; p++) begin
            if (p == 7) add_cmd(PL_CALM, '0);
            add_cmd(PL_CFG, SCAN_W'(phase_scan[p]));
            if (p == 1) begin
                add_cmd(PL_HOLD, '0);
                for (int i = 0; i < 6; i++) add_beat(REQ_FREE, PAGE_W'($urandom_range(0, 191)));
            end
            if (p == 3) begin
                add_random_beats(phase_len[p] / 2, phase_scan[p]);
                add_cmd(PL_DRAIN, '0);
                add_random_beats(phase_len[p] - phase_len[p] / 2, phase_scan[p]);
            end else begin
                add_random_beats(phase_len[p], phase_scan[p]);
            end
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (req_plan.size() != 0 || req_if.valid || grant_expect.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d free/lock, %0d grants, %0d allocs with no free page,",
                 n_rw, n_grant, n_nofree);
        $display("%0d rejected requests and %0d scan_words writes incl. 0 and 2047",
                 n_bad, n_cfg);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bpa_pkg.sv
hdl/bpa_req_if.sv
hdl/bpa_rsp_if.sv
hdl/bpa_ram.sv
hdl/bpa_ctrl.sv
hdl/bpa_datapath.sv
hdl/bitmap_page_allocator_top.sv
test/tb_bitmap_page_allocator_top.sv
